// ===== hdl/pia_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the parallel interface adapter.
// Used by the top level and by its port checker; depends on nothing.
package pia_pkg;

    // Bus access direction.
    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } t_op;

    // Register map of the four byte registers.
    typedef enum logic [1:0] {
        REG_PORT_A = 2'd0,
        REG_PORT_B = 2'd1,
        REG_CTRL_A = 2'd2,
        REG_CTRL_B = 2'd3
    } t_reg_sel;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 2;
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MACHINE_TYPE = 2'd0,
        CFG_MATH_PACK    = 2'd1
    } t_cfg_index;

    // Machine types.
    localparam logic [1:0] MACHINE_OLD     = 2'd0;
    localparam logic [1:0] MACHINE_BANKED  = 2'd1;
    localparam logic [1:0] MACHINE_CONSOLE = 2'd2;

    // Control register bit positions.
    localparam int CTRL_DATA_SEL = 2;  // 1 selects the data latch, 0 the direction mask
    localparam int CTRL_MODE_LO  = 3;
    localparam int CTRL_MODE_HI  = 4;
    localparam int CTRL_OUT_EN   = 5;  // line 2 driven as an output
    localparam int CTRL_FLAG2    = 6;
    localparam int CTRL_FLAG1    = 7;

    // Output modes of line 2 when driven (control bits 4:3).
    localparam logic [1:0] LINE_MODE_PULSE = 2'b01;
    localparam logic [1:0] LINE_MODE_LOW   = 2'b10;
    localparam logic [1:0] LINE_MODE_HIGH  = 2'b11;

    // Memory mapping bit positions.
    localparam int MAP_OS       = 0;
    localparam int MAP_BASIC    = 1;
    localparam int MAP_SELFTEST = 2;
    localparam int MAP_MATHPACK = 3;
    localparam logic [3:0] MAP_RESET = 4'b1001;

    // One result transaction.
    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_line;
        logic       motor_line;
        logic       command_line;
        logic [3:0] map;
    } t_result;

endpackage

// ===== hdl/pia_port_controller.sv =====
`timescale 1ns / 1ps
// Top level of the two-port parallel interface adapter.
// Depends on pia_pkg for register codes, bit positions and the result type.
//
// Usage:
//   The input channel (i_valid / o_ready) carries one bus access per
//   transaction: a read or write of port A, port B, control A or control B,
//   together with the current joystick nibbles and paddle trigger bits.
//   The output channel (o_valid / i_ready) returns exactly one result
//   transaction per access: the byte read (zero on writes), the interrupt
//   line, the motor and command lines and the four memory mapping bits as
//   they stand after the access.
//   The result of an accepted access is registered in the output or skid
//   register. Throughput is one access per cycle while o_ready is high;
//   all work is a single pass of logic from the accepted access and the
//   adapter state into the result register.
//   When the receiver stalls, a skid register catches one more result, so
//   the input stays ready after the output stalls until that result is
//   caught; o_ready drops only while the skid register is occupied.
//   The configuration port (i_cfg_we, i_cfg_index, i_cfg_data) writes the
//   machine type and the math pack control bit; writes to other indexes are
//   ignored and a write does not recompute the memory mapping.
//   Synchronous active-low reset returns all port, control, line and
//   mapping state to power-up values and empties the output stages.
module pia_port_controller (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [pia_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [pia_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // access channel
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_operation,
    input  logic [1:0]                       i_register_select,
    input  logic [7:0]                       i_write_data,
    input  logic [3:0]                       i_stick_zero,
    input  logic [3:0]                       i_stick_one,
    input  logic [3:0]                       i_stick_two,
    input  logic [3:0]                       i_stick_three,
    input  logic [3:0]                       i_paddle_triggers,
    // result channel
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [7:0]                       o_read_data,
    output logic                             o_irq_line,
    output logic                             o_motor_line,
    output logic                             o_command_line,
    output logic                             o_map_os,
    output logic                             o_map_basic,
    output logic                             o_map_selftest,
    output logic                             o_map_mathpack
);
    import pia_pkg::*;

    // Configuration registers.
    logic [1:0] r_machine_type;
    logic       r_math_pack_ctrl;

    // Adapter state.
    logic [7:0] r_latch_a, n_latch_a;
    logic [7:0] r_latch_b, n_latch_b;
    logic [7:0] r_dir_a, n_dir_a;
    logic [7:0] r_dir_b, n_dir_b;
    logic [7:0] r_ctrl_a, n_ctrl_a;
    logic [7:0] r_ctrl_b, n_ctrl_b;
    logic       r_line_a, n_line_a;
    logic       r_line_b, n_line_b;
    logic       r_fall_a, n_fall_a;
    logic       r_rise_a, n_rise_a;
    logic       r_edge_b, n_edge_b;
    logic       r_irq, n_irq;
    logic       r_motor, n_motor;
    logic       r_command, n_command;
    logic [3:0] r_map, n_map;

    // Output stage and skid register.
    t_result    r_out, r_skid, w_result;
    logic       r_out_valid, r_skid_valid;

    logic       w_fire;
    logic       w_out_free;
    logic [7:0] w_sticks_a, w_sticks_b;
    logic [7:0] w_pb_before;
    logic [7:0] v_pb_after, v_pb_changed;
    logic [7:0] v_read;
    logic       v_os, v_selftest;

    assign o_ready    = !r_skid_valid;
    assign w_fire     = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;

    // Paddle triggers pull bits 2 and 3 of each stick nibble low.
    assign w_sticks_a = {i_stick_one[3] & ~i_paddle_triggers[3],
                         i_stick_one[2] & ~i_paddle_triggers[2], i_stick_one[1:0],
                         i_stick_zero[3] & ~i_paddle_triggers[1],
                         i_stick_zero[2] & ~i_paddle_triggers[0], i_stick_zero[1:0]};
    assign w_sticks_b = {i_stick_three[3] & ~i_paddle_triggers[3],
                         i_stick_three[2] & ~i_paddle_triggers[2], i_stick_three[1:0],
                         i_stick_two[3] & ~i_paddle_triggers[1],
                         i_stick_two[2] & ~i_paddle_triggers[0], i_stick_two[1:0]};

    // Effective port B output before this access.
    assign w_pb_before = r_latch_b | ~r_dir_b;

    // Next state and result of one access.
    always_comb begin
        n_latch_a    = r_latch_a;
        n_latch_b    = r_latch_b;
        n_dir_a      = r_dir_a;
        n_dir_b      = r_dir_b;
        n_ctrl_a     = r_ctrl_a;
        n_ctrl_b     = r_ctrl_b;
        n_line_a     = r_line_a;
        n_line_b     = r_line_b;
        n_fall_a     = r_fall_a;
        n_rise_a     = r_rise_a;
        n_edge_b     = r_edge_b;
        n_irq        = r_irq;
        n_motor      = r_motor;
        n_command    = r_command;
        n_map        = r_map;
        v_read       = 8'h00;
        v_pb_after   = 8'h00;
        v_pb_changed = 8'h00;
        v_os         = 1'b0;
        v_selftest   = 1'b0;

        if (i_operation == OP_WRITE) begin
            unique case (i_register_select)
                REG_PORT_A: begin
                    if (r_ctrl_a[CTRL_DATA_SEL]) n_latch_a = i_write_data;
                    else n_dir_a = i_write_data;
                end
                REG_PORT_B: begin
                    if (r_ctrl_b[CTRL_DATA_SEL]) n_latch_b = i_write_data;
                    else n_dir_b = i_write_data;
                    v_pb_after   = n_latch_b | ~n_dir_b;
                    v_pb_changed = w_pb_before ^ v_pb_after;
                    // The self-test ROM only shows while the OS ROM is mapped.
                    v_os       = v_pb_after[0];
                    v_selftest = ~v_pb_after[7] & v_pb_after[0];
                    if (r_machine_type == MACHINE_BANKED) begin
                        if (v_pb_changed[6] && r_math_pack_ctrl)
                            n_map[MAP_MATHPACK] = v_pb_after[6];
                        if (v_pb_changed[1])
                            n_map[MAP_BASIC] = ~v_pb_after[1];
                        if (v_pb_changed[0] || v_pb_changed[7]) begin
                            n_map[MAP_OS]       = v_os;
                            n_map[MAP_SELFTEST] = v_selftest;
                        end
                    end
                end
                REG_CTRL_A: begin
                    n_ctrl_a = {r_ctrl_a[7:6], i_write_data[5:0]};
                    if (i_write_data[CTRL_OUT_EN]) begin
                        n_ctrl_a[7:6] = 2'b00;
                        case (i_write_data[CTRL_MODE_HI:CTRL_MODE_LO])
                            LINE_MODE_LOW: begin
                                if (r_line_a) begin
                                    n_line_a = 1'b0;
                                    n_fall_a = 1'b1;
                                    n_motor  = 1'b0;
                                end
                            end
                            LINE_MODE_HIGH: begin
                                if (!r_line_a) begin
                                    n_line_a = 1'b1;
                                    n_rise_a = 1'b1;
                                    n_motor  = 1'b1;
                                end
                            end
                            LINE_MODE_PULSE: begin
                                n_line_a = 1'b1;
                                n_fall_a = 1'b0;
                                n_rise_a = 1'b0;
                                n_motor  = 1'b1;
                            end
                            default: ;
                        endcase
                    end else begin
                        // Latch the flag for the edge that the mode bit watches.
                        if ((n_ctrl_a[CTRL_MODE_HI] && r_fall_a) ||
                            (!n_ctrl_a[CTRL_MODE_HI] && r_rise_a))
                            n_ctrl_a[CTRL_FLAG2] = 1'b1;
                        n_fall_a = 1'b0;
                        n_rise_a = 1'b0;
                    end
                    n_irq = n_ctrl_a[CTRL_FLAG2] & ~n_ctrl_a[CTRL_OUT_EN] &
                            n_ctrl_a[CTRL_MODE_LO];
                end
                REG_CTRL_B: begin
                    n_ctrl_b = {r_ctrl_b[7:6], i_write_data[5:0]};
                    if (i_write_data[CTRL_OUT_EN]) begin
                        n_ctrl_b[7:6] = 2'b00;
                        case (i_write_data[CTRL_MODE_HI:CTRL_MODE_LO])
                            LINE_MODE_LOW: begin
                                if (r_line_b) begin
                                    n_line_b  = 1'b0;
                                    n_edge_b  = 1'b0;
                                    n_command = 1'b1;
                                end
                            end
                            LINE_MODE_HIGH: begin
                                if (!r_line_b) begin
                                    n_line_b  = 1'b1;
                                    n_edge_b  = 1'b1;
                                    n_command = 1'b0;
                                end
                            end
                            LINE_MODE_PULSE: begin
                                n_line_b = 1'b1;
                                n_edge_b = 1'b0;
                            end
                            default: ;
                        endcase
                    end else begin
                        if (r_edge_b) begin
                            n_ctrl_b[CTRL_FLAG2] = 1'b1;
                            n_edge_b             = 1'b0;
                        end
                        n_line_b = 1'b1;
                    end
                    n_irq = n_ctrl_b[CTRL_FLAG2] & ~n_ctrl_b[CTRL_OUT_EN] &
                            n_ctrl_b[CTRL_MODE_LO];
                end
                default: ;
            endcase
        end else begin
            unique case (i_register_select)
                REG_PORT_A: begin
                    if (!r_ctrl_a[CTRL_DATA_SEL]) begin
                        v_read = r_dir_a;
                    end else begin
                        n_ctrl_a = {2'b00, r_ctrl_a[5:0]};
                        n_irq    = 1'b0;
                        v_read   = ((r_latch_a & r_dir_a) | ~r_dir_a) & w_sticks_a;
                    end
                end
                REG_PORT_B: begin
                    if (!r_ctrl_b[CTRL_DATA_SEL]) begin
                        v_read = r_dir_b;
                    end else begin
                        n_ctrl_b = {2'b00, r_ctrl_b[5:0]};
                        n_irq    = 1'b0;
                        if (r_machine_type == MACHINE_OLD)
                            v_read = (r_latch_b & r_dir_b) | (w_sticks_b & ~r_dir_b);
                        else if (r_machine_type == MACHINE_BANKED)
                            v_read = r_latch_b | ~r_dir_b;
                        else
                            v_read = 8'hff;
                    end
                end
                REG_CTRL_A: v_read = r_ctrl_a;
                REG_CTRL_B: v_read = r_ctrl_b;
                default: ;
            endcase
        end

        w_result.read_data    = v_read;
        w_result.irq_line     = n_irq;
        w_result.motor_line   = n_motor;
        w_result.command_line = n_command;
        w_result.map          = n_map;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_machine_type   <= MACHINE_BANKED;
            r_math_pack_ctrl <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_MACHINE_TYPE) r_machine_type <= i_cfg_data[1:0];
            else if (i_cfg_index == CFG_MATH_PACK) r_math_pack_ctrl <= i_cfg_data[0];
        end
    end

    // Adapter state advances once per accepted access.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch_a <= 8'hff;
            r_latch_b <= 8'hff;
            r_dir_a   <= 8'h00;
            r_dir_b   <= 8'h00;
            r_ctrl_a  <= 8'h00;
            r_ctrl_b  <= 8'h00;
            r_line_a  <= 1'b1;
            r_line_b  <= 1'b1;
            r_fall_a  <= 1'b0;
            r_rise_a  <= 1'b0;
            r_edge_b  <= 1'b0;
            r_irq     <= 1'b0;
            r_motor   <= 1'b1;
            r_command <= 1'b0;
            r_map     <= MAP_RESET;
        end else if (w_fire) begin
            r_latch_a <= n_latch_a;
            r_latch_b <= n_latch_b;
            r_dir_a   <= n_dir_a;
            r_dir_b   <= n_dir_b;
            r_ctrl_a  <= n_ctrl_a;
            r_ctrl_b  <= n_ctrl_b;
            r_line_a  <= n_line_a;
            r_line_b  <= n_line_b;
            r_fall_a  <= n_fall_a;
            r_rise_a  <= n_rise_a;
            r_edge_b  <= n_edge_b;
            r_irq     <= n_irq;
            r_motor   <= n_motor;
            r_command <= n_command;
            r_map     <= n_map;
        end
    end

    // Output register with skid: the skid register only fills when the
    // output register is held by a stalled receiver.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_fire;
            end
        end else if (w_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_valid) r_out <= r_skid;
            else if (w_fire) r_out <= w_result;
        end else if (w_fire) begin
            r_skid <= w_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_read_data    = r_out.read_data;
    assign o_irq_line     = r_out.irq_line;
    assign o_motor_line   = r_out.motor_line;
    assign o_command_line = r_out.command_line;
    assign o_map_os       = r_out.map[MAP_OS];
    assign o_map_basic    = r_out.map[MAP_BASIC];
    assign o_map_selftest = r_out.map[MAP_SELFTEST];
    assign o_map_mathpack = r_out.map[MAP_MATHPACK];

endmodule

// ===== hdl/pia_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the parallel interface adapter, bound to the top level.
// Depends on pia_pkg for the access codes.
module pia_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       i_operation,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_read_data,
    input logic       o_irq_line,
    input logic       o_motor_line,
    input logic       o_command_line,
    input logic       o_map_os,
    input logic       o_map_basic,
    input logic       o_map_selftest,
    input logic       o_map_mathpack
);
    import pia_pkg::*;

    // Reset empties the output stages.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // The input only stalls while a result is being held.
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled with no result pending");

    // An access taken while the output path is free shows up next cycle.
    a_one_cycle_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (!o_valid || i_ready)) |=> o_valid)
        else $error("result missing one cycle after accept");

    // A write seen through a free output path returns zero data.
    a_write_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (!o_valid || i_ready) && i_operation == OP_WRITE)
        |=> o_read_data == 8'h00)
        else $error("write access returned nonzero data");

    // A held result keeps its payload.
    a_hold_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_read_data) && $stable(o_irq_line)
            && $stable(o_motor_line) && $stable(o_command_line) && $stable(o_map_os)
            && $stable(o_map_basic) && $stable(o_map_selftest) && $stable(o_map_mathpack)))
        else $error("stalled result changed");

endmodule

bind pia_port_controller pia_checker u_pia_checker (.*);
